@@ design/gvdc_pkg.sv @@
// Package for the grid vertex domination collapse block.
// Holds field widths, codes, controller states and the controller/datapath bundles.
// No dependencies.
`default_nettype none

package gvdc_pkg;

  localparam int COORD_W   = 6;
  localparam int IDX_W     = 12;
  localparam int CNT_OUT_W = 13;
  localparam int DIMS_W    = 3;
  localparam int RAD_W     = 4;
  localparam int SIDE_W    = 6;
  localparam int DELTA_W   = 4;
  localparam int CFG_W     = 6;
  localparam int CFG_AW    = 2;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_AW-1:0] REG_DIMS  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RAD   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SIDE  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DELTA = 2'd3;

  localparam logic [DIMS_W-1:0]  DIMS_RST  = 3'd2;
  localparam logic [RAD_W-1:0]   RAD_RST   = 4'd1;
  localparam logic [SIDE_W-1:0]  SIDE_RST  = 6'd3;
  localparam logic [DELTA_W-1:0] DELTA_RST = 4'd2;

  localparam logic CMD_RUN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RWAIT, S_OUT, S_SIZE, S_FILL, S_START, S_PASS,
    S_VISIT, S_VWAIT, S_DTEST, S_WADDR, S_WWAIT, S_OTEST, S_OADDR, S_OWAIT,
    S_REMOVE, S_NEXTP
  } state_t;

  typedef struct packed {
    logic rd_idx;
    logic res_read;
    logic res_run;
    logic res_refuse;
    logic size_start;
    logic size_step;
    logic sweep_init;
    logic sweep_fill;
    logic run_init;
    logic pass_start;
    logic rd_p;
    logic p_next;
    logic dv_dec;
    logic d_start;
    logic d_next;
    logic o_start;
    logic o_next;
    logic addr_start;
    logic addr_sel_o;
    logic addr_step;
    logic rd_addr;
    logic remove;
  } ctl_cmd_t;

  typedef struct packed {
    logic size_bad;
    logic npts_over;
    logic size_done;
    logic fill_last;
    logic clr_last;
    logic match;
    logic rd_bit;
    logic dv_zero;
    logic lim_zero;
    logic d_ok;
    logic d_last;
    logic o_ok;
    logic o_far;
    logic o_last;
    logic addr_oob;
    logic keep_going;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ design/gvdc_ctrl.sv @@
// Controller state machine for the collapse block.
// Drives the datapath by command bundle; depends on gvdc_pkg.
`default_nettype none

module gvdc_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire                     in_cmd,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  input  gvdc_pkg::dp_sts_t       sts,
  output gvdc_pkg::ctl_cmd_t      cmd
);

  gvdc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gvdc_pkg::S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign in_tready  = (state_r == gvdc_pkg::S_IDLE);
  assign out_tvalid = (state_r == gvdc_pkg::S_OUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gvdc_pkg::S_CLEAR: if (sts.clr_last) state_nxt = gvdc_pkg::S_IDLE;
      gvdc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_cmd == gvdc_pkg::CMD_READ) state_nxt = gvdc_pkg::S_RWAIT;
          else                              state_nxt = gvdc_pkg::S_SIZE;
        end
      end
      gvdc_pkg::S_RWAIT: state_nxt = gvdc_pkg::S_OUT;
      gvdc_pkg::S_OUT: if (out_tready) state_nxt = gvdc_pkg::S_IDLE;
      gvdc_pkg::S_SIZE: begin
        if (sts.size_bad || sts.npts_over) state_nxt = gvdc_pkg::S_OUT;
        else if (sts.size_done)            state_nxt = gvdc_pkg::S_FILL;
      end
      gvdc_pkg::S_FILL: if (sts.fill_last) state_nxt = gvdc_pkg::S_START;
      gvdc_pkg::S_START: state_nxt = gvdc_pkg::S_PASS;
      gvdc_pkg::S_PASS: begin
        if (sts.keep_going) state_nxt = gvdc_pkg::S_VISIT;
        else                state_nxt = gvdc_pkg::S_OUT;
      end
      gvdc_pkg::S_VISIT: begin
        if (sts.match) state_nxt = gvdc_pkg::S_VWAIT;
        else           state_nxt = gvdc_pkg::S_NEXTP;
      end
      gvdc_pkg::S_VWAIT: begin
        if (sts.rd_bit && !sts.lim_zero) state_nxt = gvdc_pkg::S_DTEST;
        else                             state_nxt = gvdc_pkg::S_NEXTP;
      end
      gvdc_pkg::S_DTEST: begin
        if (sts.d_ok)        state_nxt = gvdc_pkg::S_WADDR;
        else if (sts.d_last) state_nxt = gvdc_pkg::S_NEXTP;
      end
      gvdc_pkg::S_WADDR: begin
        if (sts.size_done) begin
          if (!sts.addr_oob)   state_nxt = gvdc_pkg::S_WWAIT;
          else if (sts.d_last) state_nxt = gvdc_pkg::S_NEXTP;
          else                 state_nxt = gvdc_pkg::S_DTEST;
        end
      end
      gvdc_pkg::S_WWAIT: begin
        if (sts.rd_bit)      state_nxt = gvdc_pkg::S_OTEST;
        else if (sts.d_last) state_nxt = gvdc_pkg::S_NEXTP;
        else                 state_nxt = gvdc_pkg::S_DTEST;
      end
      gvdc_pkg::S_OTEST: begin
        if (sts.o_ok)        state_nxt = gvdc_pkg::S_OADDR;
        else if (sts.o_last) state_nxt = gvdc_pkg::S_REMOVE;
      end
      gvdc_pkg::S_OADDR: begin
        if (sts.size_done) begin
          if (!sts.addr_oob)   state_nxt = gvdc_pkg::S_OWAIT;
          else if (sts.o_last) state_nxt = gvdc_pkg::S_REMOVE;
          else                 state_nxt = gvdc_pkg::S_OTEST;
        end
      end
      gvdc_pkg::S_OWAIT: begin
        if (sts.rd_bit && sts.o_far) begin
          if (sts.d_last) state_nxt = gvdc_pkg::S_NEXTP;
          else            state_nxt = gvdc_pkg::S_DTEST;
        end else if (sts.o_last) begin
          state_nxt = gvdc_pkg::S_REMOVE;
        end else begin
          state_nxt = gvdc_pkg::S_OTEST;
        end
      end
      gvdc_pkg::S_REMOVE: state_nxt = gvdc_pkg::S_NEXTP;
      gvdc_pkg::S_NEXTP: begin
        if (sts.fill_last && sts.dv_zero) state_nxt = gvdc_pkg::S_PASS;
        else                              state_nxt = gvdc_pkg::S_VISIT;
      end
      default: state_nxt = gvdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      gvdc_pkg::S_CLEAR: cmd.sweep_fill = 1'b1;
      gvdc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_cmd == gvdc_pkg::CMD_READ) cmd.rd_idx = 1'b1;
          else                              cmd.size_start = 1'b1;
        end
      end
      gvdc_pkg::S_RWAIT: cmd.res_read = 1'b1;
      gvdc_pkg::S_OUT: ;
      gvdc_pkg::S_SIZE: begin
        if (sts.size_bad || sts.npts_over) cmd.res_refuse = 1'b1;
        else if (sts.size_done)            cmd.sweep_init = 1'b1;
        else                               cmd.size_step  = 1'b1;
      end
      gvdc_pkg::S_FILL: cmd.sweep_fill = 1'b1;
      gvdc_pkg::S_START: cmd.run_init = 1'b1;
      gvdc_pkg::S_PASS: begin
        if (sts.keep_going) cmd.pass_start = 1'b1;
        else                cmd.res_run    = 1'b1;
      end
      gvdc_pkg::S_VISIT: if (sts.match) cmd.rd_p = 1'b1;
      gvdc_pkg::S_VWAIT: cmd.d_start = 1'b1;
      gvdc_pkg::S_DTEST: begin
        if (sts.d_ok) cmd.addr_start = 1'b1;
        else if (!sts.d_last) cmd.d_next = 1'b1;
      end
      gvdc_pkg::S_WADDR: begin
        if (!sts.size_done)    cmd.addr_step = 1'b1;
        else if (!sts.addr_oob) cmd.rd_addr  = 1'b1;
        else if (!sts.d_last)  cmd.d_next    = 1'b1;
      end
      gvdc_pkg::S_WWAIT: begin
        if (sts.rd_bit)       cmd.o_start = 1'b1;
        else if (!sts.d_last) cmd.d_next  = 1'b1;
      end
      gvdc_pkg::S_OTEST: begin
        if (sts.o_ok) begin
          cmd.addr_start = 1'b1;
          cmd.addr_sel_o = 1'b1;
        end else if (!sts.o_last) begin
          cmd.o_next = 1'b1;
        end
      end
      gvdc_pkg::S_OADDR: begin
        if (!sts.size_done)     cmd.addr_step = 1'b1;
        else if (!sts.addr_oob) cmd.rd_addr   = 1'b1;
        else if (!sts.o_last)   cmd.o_next    = 1'b1;
      end
      gvdc_pkg::S_OWAIT: begin
        // a live witness too far from the candidate: drop this candidate
        if (sts.rd_bit && sts.o_far) begin
          if (!sts.d_last) cmd.d_next = 1'b1;
        end else if (!sts.o_last) begin
          cmd.o_next = 1'b1;
        end
      end
      gvdc_pkg::S_REMOVE: cmd.remove = 1'b1;
      gvdc_pkg::S_NEXTP: begin
        if (!sts.fill_last)    cmd.p_next = 1'b1;
        else if (!sts.dv_zero) cmd.dv_dec = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/gvdc_datapath.sv @@
// Datapath: configuration registers, alive bitmap, point and offset counters,
// axis-serial address unit and result register. Depends on gvdc_pkg.
`default_nettype none

module gvdc_datapath #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_DIMS     = 4,
  parameter int MAX_RADIUS   = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [gvdc_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire [gvdc_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire [gvdc_pkg::IDX_W-1:0]        in_idx,
  input  gvdc_pkg::ctl_cmd_t               cmd,
  output gvdc_pkg::dp_sts_t                sts,
  output logic                             res_is_alive,
  output logic [gvdc_pkg::CNT_OUT_W-1:0]   res_core,
  output logic [gvdc_pkg::CNT_OUT_W-1:0]   res_pass,
  output logic                             res_status
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CW   = AW + 1;
  localparam int NPW  = AW + 8;
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int OW   = RW + 1;
  localparam int DW   = OW + 1;
  localparam int SW   = DW + $clog2(MAX_DIMS + 1);
  localparam int DVW  = $clog2(MAX_DIMS * 63 + 1);
  localparam int AXW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int XW   = ((OW > 7) ? OW : 7) + 1;
  localparam int CO   = gvdc_pkg::COORD_W;

  // configuration
  logic [gvdc_pkg::DIMS_W-1:0]  dims_r;
  logic [gvdc_pkg::RAD_W-1:0]   rad_r;
  logic [gvdc_pkg::SIDE_W-1:0]  side_r;
  logic [gvdc_pkg::DELTA_W-1:0] delta_r;

  // run parameters
  logic [gvdc_pkg::DIMS_W-1:0] n_r;
  logic [CO-1:0]               m_r;
  logic [RW-1:0]               r_r, lim_r;
  logic [NPW-1:0]              npts_r;
  logic [CW-1:0]               stride_r [MAX_DIMS];
  logic [AXW:0]                ax_r;

  // walk state
  logic [AW-1:0]               p_r;
  logic [CO-1:0]               c_r [MAX_DIMS];
  logic [DVW-1:0]              dv_r;
  logic signed [OW-1:0]        d_r [MAX_DIMS];
  logic signed [OW-1:0]        o_r [MAX_DIMS];
  logic [AW-1:0]               acc_r;
  logic                        oob_r, sel_o_r;
  logic [CW-1:0]               left_r, pass_r;
  logic                        changed_r;

  // bitmap
  logic                        mem [MAX_VERTICES];
  logic                        rd_r, rng_r;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;

  // derived
  logic [RW-1:0]               r_sat, k_sat;
  logic signed [OW-1:0]        lim_s, r_s;
  logic signed [OW-1:0]        d_nxt [MAX_DIMS];
  logic signed [OW-1:0]        o_nxt [MAX_DIMS];
  logic [CO-1:0]               c_nxt [MAX_DIMS];
  logic [SW-1:0]               d_l1, o_l1, od_l1;
  logic [DVW-1:0]              cd;
  logic                        d_last, o_last;
  logic signed [XW-1:0]        x_step;
  logic signed [OW-1:0]        off_sel;
  logic [CW+XW-1:0]            prod;
  logic                        in_rng;

  always_comb begin
    r_sat = (int'(rad_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_r);
    k_sat = (int'(delta_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(delta_r);
  end

  assign lim_s = $signed({1'b0, lim_r});
  assign r_s   = $signed({1'b0, r_r});

  // offset odometers, sums and centre distance
  always_comb begin
    logic dc, oc;
    logic signed [OW-1:0] da, oa;
    logic signed [DW-1:0] df;
    logic signed [XW-1:0] t;
    logic cc;
    dc = 1'b1; oc = 1'b1; cc = 1'b1;
    da = '0; oa = '0; df = '0; t = '0;
    d_l1 = '0; o_l1 = '0; od_l1 = '0; cd = '0;
    d_last = 1'b1; o_last = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      d_nxt[i] = d_r[i];
      o_nxt[i] = o_r[i];
      c_nxt[i] = c_r[i];
      if (i < int'(n_r)) begin
        if (dc) begin
          if (d_r[i] < lim_s) begin
            d_nxt[i] = d_r[i] + OW'(1);
            dc = 1'b0;
          end else begin
            d_nxt[i] = -lim_s;
          end
        end
        if (oc) begin
          if (o_r[i] < r_s) begin
            o_nxt[i] = o_r[i] + OW'(1);
            oc = 1'b0;
          end else begin
            o_nxt[i] = -r_s;
          end
        end
        if (cc) begin
          if (c_r[i] == m_r) begin
            c_nxt[i] = '0;
          end else begin
            c_nxt[i] = c_r[i] + CO'(1);
            cc = 1'b0;
          end
        end
        if (d_r[i] != lim_s) d_last = 1'b0;
        if (o_r[i] != r_s)   o_last = 1'b0;
        da = (d_r[i] < 0) ? -d_r[i] : d_r[i];
        oa = (o_r[i] < 0) ? -o_r[i] : o_r[i];
        df = DW'(o_r[i]) - DW'(d_r[i]);
        if (df < 0) df = -df;
        d_l1  = d_l1 + SW'($unsigned(da));
        o_l1  = o_l1 + SW'($unsigned(oa));
        od_l1 = od_l1 + SW'($unsigned(df));
        t = $signed(XW'({c_r[i], 1'b0})) - $signed(XW'(m_r));
        if (t < 0) t = -t;
        cd = cd + DVW'($unsigned(t));
      end
    end
  end

  // one axis of the neighbour address per cycle
  always_comb begin
    off_sel = sel_o_r ? o_r[ax_r[AXW-1:0]] : d_r[ax_r[AXW-1:0]];
    x_step  = $signed(XW'(c_r[ax_r[AXW-1:0]])) + XW'(off_sel);
    prod    = (CW + XW)'($unsigned(x_step[XW-2:0])) * (CW + XW)'(stride_r[ax_r[AXW-1:0]]);
  end

  assign in_rng  = (int'(in_idx) < MAX_VERTICES);
  assign rd_addr = cmd.rd_idx ? AW'(in_idx) : (cmd.rd_addr ? acc_r : p_r);
  assign wr_en   = cmd.sweep_fill || cmd.remove;

  always_ff @(posedge clk) begin
    if (wr_en) mem[p_r] <= ~cmd.remove;
    if (cmd.rd_idx || cmd.rd_p || cmd.rd_addr) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r    <= gvdc_pkg::DIMS_RST;
      rad_r     <= gvdc_pkg::RAD_RST;
      side_r    <= gvdc_pkg::SIDE_RST;
      delta_r   <= gvdc_pkg::DELTA_RST;
      p_r       <= '0;
      left_r    <= '0;
      pass_r    <= '0;
      changed_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          gvdc_pkg::REG_DIMS:  dims_r  <= cfg_wdata[gvdc_pkg::DIMS_W-1:0];
          gvdc_pkg::REG_RAD:   rad_r   <= cfg_wdata[gvdc_pkg::RAD_W-1:0];
          gvdc_pkg::REG_SIDE:  side_r  <= cfg_wdata[gvdc_pkg::SIDE_W-1:0];
          gvdc_pkg::REG_DELTA: delta_r <= cfg_wdata[gvdc_pkg::DELTA_W-1:0];
          default: ;
        endcase
      end
      if (cmd.sweep_init || cmd.pass_start || cmd.dv_dec) p_r <= '0;
      else if (cmd.sweep_fill || cmd.p_next)              p_r <= p_r + AW'(1);
      if (cmd.run_init) begin
        left_r    <= CW'(npts_r);
        pass_r    <= '0;
        changed_r <= 1'b1;
      end
      if (cmd.pass_start) begin
        changed_r <= 1'b0;
        pass_r    <= pass_r + CW'(1);
      end
      if (cmd.remove) begin
        left_r    <= left_r - CW'(1);
        changed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_idx) rng_r <= in_rng;
    if (cmd.size_start) begin
      n_r    <= dims_r;
      m_r    <= side_r;
      r_r    <= r_sat;
      lim_r  <= (k_sat < r_sat) ? k_sat : r_sat;
      npts_r <= NPW'(1);
      ax_r   <= '0;
    end
    if (cmd.size_step) begin
      stride_r[ax_r[AXW-1:0]] <= CW'(npts_r);
      npts_r <= NPW'(npts_r * NPW'({1'b0, m_r} + 7'd1));
      ax_r   <= ax_r + (AXW + 1)'(1);
    end
    if (cmd.pass_start || cmd.dv_dec || cmd.sweep_init) begin
      for (int i = 0; i < MAX_DIMS; i++) c_r[i] <= '0;
    end else if (cmd.p_next) begin
      for (int i = 0; i < MAX_DIMS; i++) c_r[i] <= c_nxt[i];
    end
    if (cmd.pass_start) dv_r <= DVW'(n_r) * DVW'(m_r);
    else if (cmd.dv_dec) dv_r <= dv_r - DVW'(1);
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (cmd.d_start)     d_r[i] <= (i < int'(n_r)) ? -lim_s : '0;
      else if (cmd.d_next) d_r[i] <= d_nxt[i];
      if (cmd.o_start)     o_r[i] <= (i < int'(n_r)) ? -r_s : '0;
      else if (cmd.o_next) o_r[i] <= o_nxt[i];
    end
    if (cmd.addr_start) begin
      acc_r   <= '0;
      oob_r   <= 1'b0;
      sel_o_r <= cmd.addr_sel_o;
      ax_r    <= '0;
    end else if (cmd.addr_step) begin
      if (x_step < 0 || x_step > $signed(XW'(m_r))) oob_r <= 1'b1;
      acc_r <= acc_r + AW'(prod);
      ax_r  <= ax_r + (AXW + 1)'(1);
    end
    if (cmd.res_read) begin
      res_is_alive <= rd_r & rng_r;
      res_core     <= gvdc_pkg::CNT_OUT_W'(left_r);
      res_pass     <= gvdc_pkg::CNT_OUT_W'(pass_r);
      res_status   <= gvdc_pkg::ST_OK;
    end else if (cmd.res_run) begin
      res_is_alive <= 1'b0;
      res_core     <= gvdc_pkg::CNT_OUT_W'(left_r);
      res_pass     <= gvdc_pkg::CNT_OUT_W'(pass_r);
      res_status   <= gvdc_pkg::ST_OK;
    end else if (cmd.res_refuse) begin
      res_is_alive <= 1'b0;
      res_core     <= '0;
      res_pass     <= '0;
      res_status   <= gvdc_pkg::ST_REFUSED;
    end
  end

  always_comb begin
    sts.size_bad   = int'(n_r) > MAX_DIMS;
    sts.npts_over  = npts_r > NPW'(MAX_VERTICES);
    sts.size_done  = int'(ax_r) == int'(n_r);
    sts.fill_last  = NPW'(p_r) == npts_r - NPW'(1);
    sts.clr_last   = p_r == AW'(MAX_VERTICES - 1);
    sts.match      = cd == dv_r;
    sts.rd_bit     = rd_r;
    sts.dv_zero    = dv_r == '0;
    sts.lim_zero   = lim_r == '0;
    sts.d_ok       = (d_l1 != '0) && (d_l1 <= SW'(lim_r));
    sts.d_last     = d_last;
    sts.o_ok       = o_l1 <= SW'(r_r);
    sts.o_far      = od_l1 > SW'(r_r);
    sts.o_last     = o_last;
    sts.addr_oob   = oob_r;
    sts.keep_going = changed_r && (left_r > CW'(1));
  end

endmodule

`default_nettype wire

@@ design/grid_vertex_domination_collapse.sv @@
// Top level of the grid vertex domination collapse block.
// Joins gvdc_ctrl and gvdc_datapath; depends on gvdc_pkg.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tuser: cmd; tdata: vertex_index
//   out_     out  out_tvalid/out_tready tdata: is_alive, core_count, pass_count, status
//   cfg_     in   cfg_we               cfg_addr, cfg_wdata
//
// A read goes from IDLE through RWAIT to OUT and holds its result there until it is taken.
// A run takes roughly
// passes * (dims*side+1) * points visits, each live point sweeping candidate offsets
// and witness offsets with one bitmap read each; the single bitmap port sets the pace.
// After reset a clearing sweep over all MAX_VERTICES entries sets the bitmap before input opens.
// One request is in flight at a time; a held result blocks the next request.
`default_nettype none

module grid_vertex_domination_collapse #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_DIMS     = 4,
  parameter int MAX_RADIUS   = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [15:0]  in_tdata,   // [11:0] vertex_index
  input  wire         in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [0] is_alive, [13:1] core_count, [26:14] pass_count,
                                  // [27] status
  input  wire         cfg_we,
  input  wire [1:0]   cfg_addr,
  input  wire [5:0]   cfg_wdata
);

  gvdc_pkg::ctl_cmd_t cmd;
  gvdc_pkg::dp_sts_t  sts;
  logic                              res_is_alive;
  logic [gvdc_pkg::CNT_OUT_W-1:0]    res_core;
  logic [gvdc_pkg::CNT_OUT_W-1:0]    res_pass;
  logic                              res_status;

  gvdc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gvdc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DIMS     (MAX_DIMS),
    .MAX_RADIUS   (MAX_RADIUS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_idx       (in_tdata[gvdc_pkg::IDX_W-1:0]),
    .cmd          (cmd),
    .sts          (sts),
    .res_is_alive (res_is_alive),
    .res_core     (res_core),
    .res_pass     (res_pass),
    .res_status   (res_status)
  );

  assign out_tdata = {4'd0, res_status, res_pass, res_core, res_is_alive};

endmodule

`default_nettype wire

@@ dv/grid_vertex_domination_collapse_tb.sv @@
// Testbench for grid_vertex_domination_collapse: run and read requests with bursty input
// and a stalling receiver, checked against a built-in collapse predictor.
// Depends on gvdc_pkg and the design sources.
`default_nettype none

typedef struct {
  bit        alive;
  bit [12:0] core;
  bit [12:0] passes;
  bit        status;
} gvdc_result_t;

class collapse_scoreboard;
  bit [2:0]     dims_r;
  bit [3:0]     rad_r;
  bit [5:0]     side_r;
  bit [3:0]     delta_r;
  bit           alive_map[4096];
  bit [12:0]    left_q;
  bit [12:0]    passes_q;
  gvdc_result_t expected_q[$];
  int           errors;
  int           n_runs, n_reads, n_refused, n_checked;
  int           g_n, g_m, g_r, g_k;
  int           stride[4];

  function new();
    dims_r = gvdc_pkg::DIMS_RST;
    rad_r = gvdc_pkg::RAD_RST;
    side_r = gvdc_pkg::SIDE_RST;
    delta_r = gvdc_pkg::DELTA_RST;
    foreach (alive_map[i]) alive_map[i] = 1'b1;
  endfunction

  function void set_reg(bit [1:0] idx, bit [5:0] val);
    case (idx)
      gvdc_pkg::REG_DIMS:  dims_r = val[2:0];
      gvdc_pkg::REG_RAD:   rad_r = val[3:0];
      gvdc_pkg::REG_SIDE:  side_r = val;
      gvdc_pkg::REG_DELTA: delta_r = val[3:0];
    endcase
  endfunction

  function bit step_offset(ref int o[4], input int lim);
    for (int i = 0; i < g_n; i++) begin
      if (o[i] < lim) begin
        o[i]++;
        return 1;
      end
      o[i] = -lim;
    end
    return 0;
  endfunction

  function bit locate(int c[4], int o[4], output int idx);
    int a;
    a = 0;
    idx = 0;
    for (int i = 0; i < g_n; i++) begin
      if (c[i] + o[i] < 0 || c[i] + o[i] > g_m) return 0;
      a += (c[i] + o[i]) * stride[i];
    end
    idx = a;
    return 1;
  endfunction

  function int l1_len(int o[4]);
    int s;
    s = 0;
    for (int i = 0; i < g_n; i++) s += (o[i] < 0) ? -o[i] : o[i];
    return s;
  endfunction

  // w = c + d dominates c when no live point near c lies beyond radius of w
  function bit covers(int c[4], int d[4]);
    int o[4];
    int u, s, t;
    for (int i = 0; i < 4; i++) o[i] = -g_r;
    do begin
      if (l1_len(o) <= g_r && locate(c, o, u) && u < 4096 && alive_map[u]) begin
        s = 0;
        for (int i = 0; i < g_n; i++) begin
          t = o[i] - d[i];
          s += (t < 0) ? -t : t;
        end
        if (s > g_r) return 0;
      end
    end while (step_offset(o, g_r));
    return 1;
  endfunction

  function bit collapsible(int c[4]);
    int d[4];
    int w, s, lim;
    lim = (g_k < g_r) ? g_k : g_r;
    if (lim == 0) return 0;
    for (int i = 0; i < 4; i++) d[i] = -lim;
    do begin
      s = l1_len(d);
      if (s > 0 && s <= lim && locate(c, d, w) && w < 4096 && alive_map[w] && covers(c, d))
        return 1;
    end while (step_offset(d, lim));
    return 0;
  endfunction

  function void coords(int p, output int c[4]);
    for (int i = 0; i < 4; i++) c[i] = 0;
    for (int i = 0; i < g_n; i++) begin
      c[i] = p % (g_m + 1);
      p = p / (g_m + 1);
    end
  endfunction

  function gvdc_result_t collapse_box();
    gvdc_result_t res;
    int c[4];
    int npts, left, pass, s, p;
    int ctr_len[4096];
    int order[$];
    bit changed;
    res = '{1'b0, 13'd0, 13'd0, gvdc_pkg::ST_REFUSED};
    if (dims_r > 4) return res;
    g_n = dims_r;
    g_m = side_r;
    g_r = (rad_r > 8) ? 8 : rad_r;
    g_k = (delta_r > 8) ? 8 : delta_r;
    npts = 1;
    for (int i = 0; i < g_n; i++) begin
      stride[i] = npts;
      npts *= g_m + 1;
      if (npts > 4096) return res;
    end
    for (p = 0; p < npts; p++) begin
      coords(p, c);
      s = 0;
      for (int i = 0; i < g_n; i++) s += (2 * c[i] > g_m) ? 2 * c[i] - g_m : g_m - 2 * c[i];
      ctr_len[p] = s;
      alive_map[p] = 1'b1;
    end
    for (int dv = g_n * g_m; dv >= 0; dv--)
      for (p = 0; p < npts; p++)
        if (ctr_len[p] == dv) order = {order, p};
    left = npts;
    pass = 0;
    changed = 1;
    while (changed && left > 1) begin
      changed = 0;
      pass++;
      foreach (order[j]) begin
        p = order[j];
        if (alive_map[p]) begin
          coords(p, c);
          if (collapsible(c)) begin
            alive_map[p] = 1'b0;
            left--;
            changed = 1;
          end
        end
      end
    end
    left_q = left[12:0];
    passes_q = pass[12:0];
    res = '{1'b0, left_q, passes_q, gvdc_pkg::ST_OK};
    return res;
  endfunction

  function void note_request(bit cmd, bit [11:0] idx);
    gvdc_result_t res;
    if (cmd == gvdc_pkg::CMD_RUN) begin
      res = collapse_box();
      n_runs++;
      if (res.status == gvdc_pkg::ST_REFUSED) n_refused++;
    end else begin
      res = '{alive_map[idx], left_q, passes_q, gvdc_pkg::ST_OK};
      n_reads++;
    end
    expected_q = {expected_q, res};
  endfunction

  task report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(bit [31:0] data);
    gvdc_result_t exp;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result %h", data));
      return;
    end
    exp = expected_q.pop_front();
    n_checked++;
    if (data[0] !== exp.alive) report($sformatf("is_alive %b want %b", data[0], exp.alive));
    if (data[13:1] !== exp.core)
      report($sformatf("core_count %0d want %0d", data[13:1], exp.core));
    if (data[26:14] !== exp.passes)
      report($sformatf("pass_count %0d want %0d", data[26:14], exp.passes));
    if (data[27] !== exp.status) report($sformatf("status %b want %b", data[27], exp.status));
  endtask
endclass

module grid_vertex_domination_collapse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [5:0]  cfg_wdata = '0;

  collapse_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int random_items = 0;

  grid_vertex_domination_collapse DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // check before noting: only one request is ever in flight
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata[11:0]);
  end

  // receiver stalls in four modes that take turns as the cycle counter advances
  always @(posedge clk) begin
    case ((cycles / 64) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_request(bit cmd, bit [11:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_box(int d, int s, int r, int k);
    drain();
    write_reg(gvdc_pkg::REG_DIMS, d[5:0]);
    write_reg(gvdc_pkg::REG_SIDE, s[5:0]);
    write_reg(gvdc_pkg::REG_RAD, r[5:0]);
    write_reg(gvdc_pkg::REG_DELTA, k[5:0]);
  endtask

  // pick a box small enough that a run stays cheap
  task automatic random_box();
    case ($urandom_range(0, 5))
      0: set_box(1, $urandom_range(0, 20), $urandom_range(0, 15), $urandom_range(0, 15));
      1: set_box(2, $urandom_range(0, 5), $urandom_range(0, 2), $urandom_range(0, 15));
      2: set_box(3, $urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(0, 15));
      3: set_box(0, $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15));
      4: begin
        if ($urandom_range(0, 1)) set_box($urandom_range(5, 7), $urandom_range(0, 63), 1, 1);
        else set_box(3, $urandom_range(20, 63), $urandom_range(1, 8), $urandom_range(1, 8));
      end
      default: set_box(1, $urandom_range(21, 63), 1, $urandom_range(1, 2));
    endcase
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // default box straight after reset, then reads inside and outside it
    send_request(gvdc_pkg::CMD_READ, 12'd0);
    send_request(gvdc_pkg::CMD_READ, 12'hfff);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    send_request(gvdc_pkg::CMD_READ, 12'd5);
    send_request(gvdc_pkg::CMD_READ, 12'd15);
    send_request(gvdc_pkg::CMD_READ, 12'd16);
    send_request(gvdc_pkg::CMD_READ, 12'hfff);
    set_box(0, 5, 1, 1);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    send_request(gvdc_pkg::CMD_READ, 12'd0);
    set_box(1, 0, 2, 2);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    set_box(5, 3, 1, 1);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    set_box(7, 1, 1, 1);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    set_box(3, 63, 1, 1);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    set_box(1, 63, 1, 1);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    send_request(gvdc_pkg::CMD_READ, 12'd63);
    send_request(gvdc_pkg::CMD_READ, 12'd32);
    set_box(1, 12, 15, 15);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    set_box(1, 6, 0, 3);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    set_box(1, 6, 3, 0);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    set_box(4, 1, 1, 1);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    send_request(gvdc_pkg::CMD_READ, 12'd15);
    set_box(2, 3, 2, 2);
    send_request(gvdc_pkg::CMD_RUN, 12'd0);
    send_request(gvdc_pkg::CMD_READ, 12'd6);

    while (random_items < 75) begin
      random_box();
      send_request(gvdc_pkg::CMD_RUN, $urandom_range(0, 4095));
      n = $urandom_range(5, 12);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) send_request(gvdc_pkg::CMD_RUN, $urandom_range(0, 4095));
        else if ($urandom_range(0, 1)) send_request(gvdc_pkg::CMD_READ, $urandom_range(0, 63));
        else send_request(gvdc_pkg::CMD_READ, $urandom_range(0, 4095));
      end
      random_items += n + 1;
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d runs (%0d refused) and %0d reads, %0d results checked",
             sb.n_runs, sb.n_refused, sb.n_reads, sb.n_checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
